// ----- design/sat_pkg.sv -----
// Shared opcodes, status codes and sequencer states for the subnet address table.
package sat_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SUBNET = 2'd1,
		OP_EXACT  = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_DUP  = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	localparam int ADDR_W = 32;
	localparam int IFC_W  = 8;

endpackage

// ----- design/sat_req_if.sv -----
// Request channel of the subnet address table: operation, address, mask, interface.
interface sat_req_if;
	logic                       valid;
	logic                       ready;
	sat_pkg::opcode_t           opcode;
	logic [sat_pkg::ADDR_W-1:0] address;
	logic [sat_pkg::ADDR_W-1:0] mask;
	logic [sat_pkg::IFC_W-1:0]  interface_id;

	modport source (output valid, output opcode, output address, output mask,
		output interface_id, input ready);
	modport sink (input valid, input opcode, input address, input mask,
		input interface_id, output ready);
endinterface

// ----- design/sat_rsp_if.sv -----
// Response channel of the subnet address table: status and the matching entry.
interface sat_rsp_if;
	logic                       valid;
	logic                       ready;
	sat_pkg::status_t           status;
	logic [sat_pkg::ADDR_W-1:0] found_address;
	logic [sat_pkg::ADDR_W-1:0] found_mask;
	logic [sat_pkg::IFC_W-1:0]  found_interface;

	modport source (output valid, output status, output found_address,
		output found_mask, output found_interface, input ready);
	modport sink (input valid, input status, input found_address,
		input found_mask, input found_interface, output ready);
endinterface

// ----- design/subnet_address_table.sv -----
// Subnet address table: sequential newest-first search over an entry memory.
// Search: each request scans the stored entries, one memory read and one compare per cycle,
//   on a single compare unit, stopping at the first hit or after the oldest entry.
// No request is accepted until the previous result has moved into the output register.
// A new request is taken while the previous response still waits on the output.
// Reset clears the entry count and all control; stored entries are not cleared.
module subnet_address_table #(
	parameter int ENTRIES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	sat_req_if.sink    req,
	sat_rsp_if.source  rsp
);
	import sat_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

	// entry memory
	logic [ADDR_W-1:0] mem_addr [ENTRIES];
	logic [ADDR_W-1:0] mem_mask [ENTRIES];
	logic [IFC_W-1:0]  mem_ifc  [ENTRIES];

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  ptr_q;
	logic              more_q, dv_q, last_q;

	opcode_t           op_q;
	logic [ADDR_W-1:0] addr_q, mask_q;
	logic [IFC_W-1:0]  ifc_q;

	logic [ADDR_W-1:0] rd_addr_q, rd_mask_q;
	logic [IFC_W-1:0]  rd_ifc_q;

	status_t           pend_status_q;
	logic [ADDR_W-1:0] pend_addr_q, pend_mask_q;
	logic [IFC_W-1:0]  pend_ifc_q;

	logic              out_vld_q;
	status_t           out_status_q;
	logic [ADDR_W-1:0] out_addr_q, out_mask_q;
	logic [IFC_W-1:0]  out_ifc_q;

	logic              req_fire, hit, miss_end, finish, wr_en, out_load;
	status_t           res_status;
	logic [ADDR_W-1:0] res_addr, res_mask;
	logic [IFC_W-1:0]  res_ifc;

	assign req_fire = req.valid && req.ready;

	// compare the entry read last cycle against the query
	always_comb begin
		if (op_q == OP_SUBNET) begin
			hit = dv_q && (((addr_q ^ rd_addr_q) & rd_mask_q) == '0);
		end else begin
			hit = dv_q && (addr_q == rd_addr_q);
		end
		miss_end = (dv_q && last_q && !hit) || (!dv_q && !more_q);
		finish   = hit || miss_end;
	end

	// pick the response and decide on an insert
	always_comb begin
		res_status = ST_MISS;
		res_addr   = '0;
		res_mask   = '0;
		res_ifc    = '0;
		wr_en      = 1'b0;
		unique case (op_q)
			OP_INSERT: begin
				if (hit) begin
					res_status = ST_DUP;
				end else if (count_q == FULL_CNT) begin
					res_status = ST_FULL;
				end else begin
					res_status = ST_OK;
					res_addr   = addr_q;
					res_mask   = mask_q;
					res_ifc    = ifc_q;
					wr_en      = (state_q == S_SCAN) && finish;
				end
			end
			OP_SUBNET, OP_EXACT: begin
				if (hit) begin
					res_status = ST_OK;
					res_addr   = rd_addr_q;
					res_mask   = rd_mask_q;
					res_ifc    = rd_ifc_q;
				end
			end
			default: begin
				res_status = ST_MISS;
			end
		endcase
	end

	// next state and handshake
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (finish) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_vld_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// hold state, count and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			ptr_q     <= '0;
			more_q    <= 1'b0;
			dv_q      <= 1'b0;
			last_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (req_fire) begin
				ptr_q  <= IDX_W'(count_q - CNT_W'(1));
				more_q <= (count_q != '0) && (opcode_t'(req.opcode) != OP_NONE);
				dv_q   <= 1'b0;
			end else if (state_q == S_SCAN) begin
				dv_q <= more_q;
				if (more_q) begin
					last_q <= (ptr_q == '0);
					more_q <= (ptr_q != '0);
					ptr_q  <= ptr_q - IDX_W'(1);
				end
			end
			if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// capture request and pending response
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q   <= opcode_t'(req.opcode);
			addr_q <= req.address;
			mask_q <= req.mask;
			ifc_q  <= req.interface_id;
		end
		if ((state_q == S_SCAN) && finish) begin
			pend_status_q <= res_status;
			pend_addr_q   <= res_addr;
			pend_mask_q   <= res_mask;
			pend_ifc_q    <= res_ifc;
		end
		if (out_load) begin
			out_status_q <= pend_status_q;
			out_addr_q   <= pend_addr_q;
			out_mask_q   <= pend_mask_q;
			out_ifc_q    <= pend_ifc_q;
		end
	end

	// write new entries, read one entry per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_addr[count_q[IDX_W-1:0]] <= addr_q;
			mem_mask[count_q[IDX_W-1:0]] <= mask_q;
			mem_ifc[count_q[IDX_W-1:0]]  <= ifc_q;
		end
		rd_addr_q <= mem_addr[ptr_q];
		rd_mask_q <= mem_mask[ptr_q];
		rd_ifc_q  <= mem_ifc[ptr_q];
	end

	assign rsp.valid           = out_vld_q;
	assign rsp.status          = out_status_q;
	assign rsp.found_address   = out_addr_q;
	assign rsp.found_mask      = out_mask_q;
	assign rsp.found_interface = out_ifc_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above table size");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (count_q != FULL_CNT) && (op_q == OP_INSERT))
		else $error("entry write without room or outside insert");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("entry count moved by other than one");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && (out_status_q != ST_OK)) |->
		((out_addr_q == '0) && (out_mask_q == '0) && (out_ifc_q == '0)))
		else $error("nonzero entry fields on a failed request");

endmodule
